// ----- design/alu8fb_pkg.sv -----
// Shared types, operation codes and flag constants of the 8-bit flag ALU.
package alu8fb_pkg;

	// Operation codes on req_type
	typedef enum logic [4:0] {
		OP_ADD = 5'd0,
		OP_ADC = 5'd1,
		OP_SUB = 5'd2,
		OP_SBB = 5'd3,
		OP_AND = 5'd4,
		OP_XOR = 5'd5,
		OP_OR  = 5'd6,
		OP_CMP = 5'd7,
		OP_INC = 5'd8,
		OP_DEC = 5'd9,
		OP_DAA = 5'd10,
		OP_RLC = 5'd11,
		OP_RRC = 5'd12,
		OP_RAL = 5'd13,
		OP_RAR = 5'd14,
		OP_CMA = 5'd15,
		OP_STC = 5'd16,
		OP_CMC = 5'd17,
		OP_INX = 5'd18,
		OP_DCX = 5'd19,
		OP_DAD = 5'd20
	} op_t;

	// How the flag byte is rebuilt in the last stage
	typedef enum logic [2:0] {
		FM_KEEP,    // flags pass unchanged
		FM_ADD,     // S Z AC P from sum, CY = carry out
		FM_SUB,     // S Z AC P from sum, CY = borrow (inverted carry)
		FM_INCDEC,  // S Z AC P from sum, CY untouched
		FM_DAA,     // S Z AC P from sum, CY from decode
		FM_CYONLY,  // only CY, value from decode
		FM_WORDCY   // only CY, from the 16-bit adder
	} fmode_t;

	// Flag bit positions in the flag byte
	localparam int FLAG_S  = 7;
	localparam int FLAG_Z  = 6;
	localparam int FLAG_AC = 4;
	localparam int FLAG_P  = 2;
	localparam int FLAG_CY = 0;

	// Decimal adjust constants
	localparam logic [7:0] DAA_LO_CORR = 8'h06;
	localparam logic [7:0] DAA_HI_CORR = 8'h60;
	localparam logic [3:0] BCD_MAX     = 4'h9;
	localparam logic [3:0] NIB_ONES    = 4'hf;
	localparam logic [7:0] BYTE_ONES   = 8'hff;
	localparam logic [15:0] WORD_ONES  = 16'hffff;

	// Adder setup produced by the decoder
	typedef struct packed {
		logic [7:0]  x;        // byte adder first input
		logic [7:0]  y;        // byte adder second input
		logic        cin;      // byte adder carry in
		logic        hold_acc; // result byte is acc (compare)
		logic [15:0] wy;       // word adder second input
		logic        wcin;     // word adder carry in
		fmode_t      fmode;
		logic        cy_new;   // carry for FM_DAA and FM_CYONLY
	} ctl_t;

	// Even parity: 1 when the count of ones is even
	function automatic logic even_par(input logic [7:0] v);
		return ~(^v);
	endfunction

endpackage

// ----- design/alu8fb_decode.sv -----
// Operation decoder: maps a request onto the shared byte and word adders.
module alu8fb_decode (
	input  logic [4:0]        req_type,
	input  logic [7:0]        acc,
	input  logic [7:0]        operand,
	input  logic [7:0]        psw_in,
	input  logic [15:0]       hl_value,
	output alu8fb_pkg::ctl_t  ctl
);
	import alu8fb_pkg::*;

	logic       cy;
	logic       ac;
	logic [3:0] lo;
	logic [3:0] hi;
	logic       lo_big;
	logic       hi_fix;

	assign cy = psw_in[FLAG_CY];
	assign ac = psw_in[FLAG_AC];
	assign lo = acc[3:0];
	assign hi = acc[7:4];
	assign lo_big = (lo > BCD_MAX);
	assign hi_fix = (hi > BCD_MAX) || cy || ((hi >= BCD_MAX) && lo_big);

	// Pick adder inputs and flag mode per operation
	always_comb begin
		ctl = '0;
		ctl.x = acc;
		ctl.fmode = FM_KEEP;
		case (op_t'(req_type))
			OP_ADD, OP_ADC: begin
				ctl.y = operand;
				ctl.cin = (op_t'(req_type) == OP_ADC) ? cy : 1'b0;
				ctl.fmode = FM_ADD;
			end
			OP_SUB, OP_SBB, OP_CMP: begin
				ctl.y = ~operand;
				ctl.cin = (op_t'(req_type) == OP_SBB) ? ~cy : 1'b1;
				ctl.hold_acc = (op_t'(req_type) == OP_CMP);
				ctl.fmode = FM_SUB;
			end
			OP_AND: begin
				ctl.x = acc & operand;
				ctl.fmode = FM_ADD;
			end
			OP_XOR: begin
				ctl.x = acc ^ operand;
				ctl.fmode = FM_ADD;
			end
			OP_OR: begin
				ctl.x = acc | operand;
				ctl.fmode = FM_ADD;
			end
			OP_INC: begin
				ctl.x = operand;
				ctl.cin = 1'b1;
				ctl.fmode = FM_INCDEC;
			end
			OP_DEC: begin
				ctl.x = operand;
				ctl.y = BYTE_ONES;
				ctl.fmode = FM_INCDEC;
			end
			OP_DAA: begin
				ctl.y = ((lo_big || ac) ? DAA_LO_CORR : 8'h00) |
					(hi_fix ? DAA_HI_CORR : 8'h00);
				ctl.cy_new = cy | hi_fix;
				ctl.fmode = FM_DAA;
			end
			OP_RLC: begin
				ctl.x = {acc[6:0], acc[7]};
				ctl.cy_new = acc[7];
				ctl.fmode = FM_CYONLY;
			end
			OP_RRC: begin
				ctl.x = {acc[0], acc[7:1]};
				ctl.cy_new = acc[0];
				ctl.fmode = FM_CYONLY;
			end
			OP_RAL: begin
				ctl.x = {acc[6:0], cy};
				ctl.cy_new = acc[7];
				ctl.fmode = FM_CYONLY;
			end
			OP_RAR: begin
				ctl.x = {cy, acc[7:1]};
				ctl.cy_new = acc[0];
				ctl.fmode = FM_CYONLY;
			end
			OP_CMA: begin
				ctl.x = ~acc;
			end
			OP_STC: begin
				ctl.cy_new = 1'b1;
				ctl.fmode = FM_CYONLY;
			end
			OP_CMC: begin
				ctl.cy_new = ~cy;
				ctl.fmode = FM_CYONLY;
			end
			OP_INX: begin
				ctl.wcin = 1'b1;
			end
			OP_DCX: begin
				ctl.wy = WORD_ONES;
			end
			OP_DAD: begin
				ctl.wy = hl_value;
				ctl.fmode = FM_WORDCY;
			end
			default: begin
				ctl.fmode = FM_KEEP;
			end
		endcase
	end

endmodule

// ----- design/alu_8bit_flags_bcd.sv -----
// Top level of the 8-bit accumulator ALU with flag byte and decimal adjust.
//
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// request  | req_valid, req_stall | req_type, acc, operand, psw_in,
//          |                      | pair_value, hl_value
// result   | rsp_valid, rsp_stall | byte_result, word_result, psw_out
//
// Three register stages: decode, add (byte and word adders), flag build.
// A request enters each cycle unless stalled; its result passes stages 1, 2 and 3.
// Each stage advances when its successor is empty or advancing, so bubbles close up.
// A stalled result holds all stages behind it; nothing is dropped or repeated.
// arst_n clears the valid bits only; payload registers are not reset.
module alu_8bit_flags_bcd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [4:0]  req_type,
	input  logic [7:0]  acc,
	input  logic [7:0]  operand,
	input  logic [7:0]  psw_in,
	input  logic [15:0] pair_value,
	input  logic [15:0] hl_value,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  byte_result,
	output logic [15:0] word_result,
	output logic [7:0]  psw_out
);
	import alu8fb_pkg::*;

	ctl_t        ctl;
	logic        adv1, adv2, adv3;

	// Stage 1: decoded request
	logic        v_s1;
	ctl_t        ctl_s1;
	logic [7:0]  psw_s1;
	logic [15:0] pair_s1;

	// Stage 2: adder outputs
	logic        v_s2;
	logic [7:0]  sum_s2;
	logic [7:0]  byte_s2;
	logic        hc_s2;
	logic        c8_s2;
	logic [15:0] word_s2;
	logic        wc_s2;
	logic [7:0]  psw_s2;
	fmode_t      fmode_s2;
	logic        cyn_s2;

	// Stage 3: output register
	logic        v_s3;
	logic [7:0]  byte_s3;
	logic [15:0] word_s3;
	logic [7:0]  psw_s3;

	logic [8:0]  sum9;
	logic [4:0]  nib5;
	logic [16:0] sum17;
	logic [7:0]  szap;
	logic [7:0]  psw_nx;

	alu8fb_decode u_decode (
		.req_type (req_type),
		.acc      (acc),
		.operand  (operand),
		.psw_in   (psw_in),
		.hl_value (hl_value),
		.ctl      (ctl)
	);

	// Advance each stage when the next one has room
	assign adv3 = !v_s3 || !rsp_stall;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign req_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Capture decoded request
	always_ff @(posedge clk) begin
		if (adv1 && req_valid) begin
			ctl_s1  <= ctl;
			psw_s1  <= psw_in;
			pair_s1 <= pair_value;
		end
	end

	// Byte and word adders
	assign sum9  = {1'b0, ctl_s1.x} + {1'b0, ctl_s1.y} + {8'd0, ctl_s1.cin};
	assign nib5  = {1'b0, ctl_s1.x[3:0]} + {1'b0, ctl_s1.y[3:0]} + {4'd0, ctl_s1.cin};
	assign sum17 = {1'b0, pair_s1} + {1'b0, ctl_s1.wy} + {16'd0, ctl_s1.wcin};

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			sum_s2   <= sum9[7:0];
			byte_s2  <= ctl_s1.hold_acc ? ctl_s1.x : sum9[7:0];
			hc_s2    <= nib5[4];
			c8_s2    <= sum9[8];
			word_s2  <= sum17[15:0];
			wc_s2    <= sum17[16];
			psw_s2   <= psw_s1;
			fmode_s2 <= ctl_s1.fmode;
			cyn_s2   <= ctl_s1.cy_new;
		end
	end

	// Build sign, zero, aux carry and parity from the byte sum
	always_comb begin
		szap = '0;
		szap[FLAG_S]  = sum_s2[7];
		szap[FLAG_Z]  = (sum_s2 == 8'h00);
		szap[FLAG_AC] = hc_s2;
		szap[FLAG_P]  = even_par(sum_s2);
	end

	// Merge new flags into the incoming flag byte
	always_comb begin
		psw_nx = psw_s2;
		case (fmode_s2)
			FM_KEEP: begin
				psw_nx = psw_s2;
			end
			FM_ADD: begin
				psw_nx = (psw_s2 & 8'b0010_1010) | szap;
				psw_nx[FLAG_CY] = c8_s2;
			end
			FM_SUB: begin
				psw_nx = (psw_s2 & 8'b0010_1010) | szap;
				psw_nx[FLAG_CY] = ~c8_s2;
			end
			FM_INCDEC: begin
				psw_nx = (psw_s2 & 8'b0010_1011) | szap;
			end
			FM_DAA: begin
				psw_nx = (psw_s2 & 8'b0010_1010) | szap;
				psw_nx[FLAG_CY] = cyn_s2;
			end
			FM_CYONLY: begin
				psw_nx[FLAG_CY] = cyn_s2;
			end
			FM_WORDCY: begin
				psw_nx[FLAG_CY] = wc_s2;
			end
			default: begin
				psw_nx = psw_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			byte_s3 <= byte_s2;
			word_s3 <= word_s2;
			psw_s3  <= psw_nx;
		end
	end

	assign rsp_valid   = v_s3;
	assign byte_result = byte_s3;
	assign word_result = word_s3;
	assign psw_out     = psw_s3;

	// Input backs up only when every stage is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && v_s2 && v_s3 && rsp_stall))
		else $error("request stalled while pipeline has room");

	// An accepted request occupies stage 1 on the next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> v_s1)
		else $error("accepted request lost at stage 1");

	// A blocked stage 2 holds its item
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv3) |=> (v_s2 && $stable(byte_s2) && $stable(word_s2)))
		else $error("stage 2 item changed while blocked");

endmodule
